/* sv/two_voice_adsr_on_time_envelope_defines.svh */
// Assertion macros for the two-voice ADSR on-time envelope.
// Define ASSERT_OFF to compile every check out; no other dependencies.
`ifndef TWO_VOICE_ADSR_ON_TIME_ENVELOPE_DEFINES_SVH
`define TWO_VOICE_ADSR_ON_TIME_ENVELOPE_DEFINES_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent
`define TVA_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define TVA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define TVA_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define TVA_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* sv/tva_pkg.sv */
// Shared types, constants and the sustain level table for the envelope block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package tva_pkg;

   // Fixed field widths
   localparam int OP_W             = 2;
   localparam int ONTIME_W         = 16;
   localparam int PHASE_W          = 3;
   localparam int COEF_W           = 18;
   localparam int DECAY_COEF_W     = 17;
   localparam int RELEASE_COEF_W   = 17;
   localparam int LEVEL_W          = 7;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 18;
   localparam int VOICES_DEFAULT   = 2;

   // Fixed-point format of the multiplier
   localparam int FRAC_BITS        = 16;
   localparam int MULT_W           = FRAC_BITS + 2;
   localparam int PROD_W           = MULT_W + COEF_W;
   localparam int CMP_W            = (MULT_W > COEF_W) ? MULT_W : COEF_W;
   localparam int DEC_W            = MULT_W + LEVEL_W;
   localparam int LEVEL_FULL       = 100;
   localparam int MILLI_DIV        = 1000;
   localparam int MILLI_ROUND      = MILLI_DIV / 2;
   localparam int LEVEL_ENTRIES    = 2 ** LEVEL_W;

   localparam logic [MULT_W-1:0] ONE_FX     = MULT_W'(1) << FRAC_BITS;
   localparam logic [MULT_W-1:0] MULT_MAX   = '1;
   localparam logic [MULT_W-1:0] START_MULT =
      MULT_W'(((64'd1 << FRAC_BITS) + 64'(MILLI_ROUND)) / 64'(MILLI_DIV));

   // Register reset values
   localparam logic [COEF_W-1:0]         ATTACK_COEF_RESET  = COEF_W'(65536);
   localparam logic [RELEASE_COEF_W-1:0] RELEASE_COEF_RESET = RELEASE_COEF_W'(65536);

   typedef enum logic [OP_W-1:0] {
      OP_TICK       = 2'd0,
      OP_NOTE_START = 2'd1,
      OP_NOTE_STOP  = 2'd2,
      OP_ALL_OFF    = 2'd3
   } op_type;

   typedef enum logic [PHASE_W-1:0] {
      PH_OFF     = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_ON_TIME     = 3'd0,
      CSR_ATTACK_COEF     = 3'd1,
      CSR_DECAY_COEF      = 3'd2,
      CSR_RELEASE_COEF    = 3'd3,
      CSR_SUSTAIN_ENABLED = 3'd4,
      CSR_SUSTAIN_LEVEL   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [OP_W-1:0]     operation;
      logic                voice;
      logic [ONTIME_W-1:0] requested_on_time;
   } req_payload_type;

   typedef struct packed {
      logic [ONTIME_W-1:0] on_time_first;
      logic [ONTIME_W-1:0] on_time_second;
      logic [PHASE_W-1:0]  phase_first;
      logic [PHASE_W-1:0]  phase_second;
      logic                any_active;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic      capture;
      logic      apply_event;
      logic      set_phase;
      phase_type phase_val;
      logic      load_start;
      logic      clear_out;
      logic      mul_scale;
      logic      scale_update;
      logic      mul_out;
      logic      out_update;
      logic      voice_next;
      logic      load_rsp;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      phase_type phase;
      logic      req_zero;
      logic      sus_en;
      logic      last_voice;
      logic      tick;
   } dp_status_type;

   // Sustain multiplier per level code, levels above full scale clamped
   typedef logic [LEVEL_ENTRIES-1:0][MULT_W-1:0] sustain_table_type;

   function automatic sustain_table_type build_sustain_table();
      sustain_table_type t;
      longint unsigned   lvl;
      for (int i = 0; i < LEVEL_ENTRIES; i++) begin
         lvl  = (i > LEVEL_FULL) ? 64'(LEVEL_FULL) : 64'(i);
         t[i] = MULT_W'((lvl << FRAC_BITS) / 64'(LEVEL_FULL));
      end
      return t;
   endfunction

   localparam sustain_table_type SUSTAIN_TABLE = build_sustain_table();

endpackage

/* sv/two_voice_adsr_on_time_envelope.sv */
// Two-voice ADSR on-time envelope. Each transaction is one event (tick, note start, note stop or
// all off) and gives exactly one result showing both voices after the event. An event other
// than a tick is applied in the dispatch state and its result registered in the response state,
// after which the input is freed; a tick steps each voice through an evaluate step and, where
// the phase needs it, two multiply-and-use pairs on the single shared 18x18 multiplier. One
// transaction is in work at a time, and the next is accepted while the previous result waits in
// the output register; a result still waiting when the next one is ready holds the block for as
// long as the receiver stalls. The user must write configuration through the csr_ port only
// while the block is idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`include "two_voice_adsr_on_time_envelope_defines.svh"

module two_voice_adsr_on_time_envelope #(
   parameter int VOICES = tva_pkg::VOICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  tva_pkg::req_payload_type        req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output tva_pkg::rsp_payload_type        rsp_payload,
   input  logic                            csr_wr_en,
   input  logic [tva_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tva_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   tva_pkg::dp_cmd_type    cmd;
   tva_pkg::dp_status_type status;
   logic                   rsp_nonzero;

   // Sequencer
   tva_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   // Envelope state and arithmetic
   tva_datapath #(
      .VOICES (VOICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .rsp_payload (rsp_payload)
   );

   // Either on-time of the result is nonzero
   assign rsp_nonzero = (rsp_payload.on_time_first != '0) || (rsp_payload.on_time_second != '0);

   // A transaction taken in makes the block busy in the next cycle
   `TVA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)

   // A result appears only at the end of work on a transaction
   `TVA_ASSERT_SAME(a_rsp_from_work, clock, reset, $rose(rsp_valid), $past(req_stall))

   // The activity flag agrees with the on-times it summarises
   `TVA_ASSERT_SAME(a_any_active, clock, reset, rsp_valid, rsp_payload.any_active == rsp_nonzero)

endmodule

/* sv/tva_ctrl.sv */
// Sequencing controller: accepts a transaction, steps the datapath through
// the voices with the shared multiplier, and holds the result register flag.
// Depends on tva_pkg.
`timescale 1ns / 1ps

module tva_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output tva_pkg::dp_cmd_type    cmd,
   input  tva_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_EVAL,
      ST_SCALE_MUL,
      ST_SCALE_USE,
      ST_OUT_MUL,
      ST_OUT_USE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      req_stall_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      voice_done;

   // Next state and commands
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      voice_done = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && !req_stall_ff) begin
               cmd.capture = 1'b1;
               state_in    = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (status.tick) begin
               state_in = ST_EVAL;
            end else begin
               cmd.apply_event = 1'b1;
               state_in        = ST_RESP;
            end
         end
         ST_EVAL: begin
            case (status.phase)
               tva_pkg::PH_OFF: begin
                  if (status.req_zero) begin
                     cmd.clear_out = 1'b1;
                     voice_done    = 1'b1;
                  end else begin
                     cmd.set_phase  = 1'b1;
                     cmd.phase_val  = tva_pkg::PH_ATTACK;
                     cmd.load_start = 1'b1;
                     state_in       = ST_SCALE_MUL;
                  end
               end
               tva_pkg::PH_ATTACK: begin
                  if (status.req_zero) begin
                     cmd.set_phase = 1'b1;
                     cmd.phase_val = tva_pkg::PH_RELEASE;
                  end
                  state_in = ST_SCALE_MUL;
               end
               tva_pkg::PH_DECAY: begin
                  if (status.req_zero) begin
                     cmd.set_phase = 1'b1;
                     cmd.phase_val = tva_pkg::PH_RELEASE;
                     state_in      = ST_SCALE_MUL;
                  end else if (status.sus_en) begin
                     state_in = ST_SCALE_MUL;
                  end else begin
                     voice_done = 1'b1;
                  end
               end
               tva_pkg::PH_SUSTAIN: begin
                  if (status.req_zero) begin
                     cmd.set_phase = 1'b1;
                     cmd.phase_val = tva_pkg::PH_RELEASE;
                     state_in      = ST_SCALE_MUL;
                  end else begin
                     voice_done = 1'b1;
                  end
               end
               tva_pkg::PH_RELEASE: begin
                  if (status.req_zero) begin
                     state_in = ST_SCALE_MUL;
                  end else begin
                     // a new note during release puts the voice back into attack
                     cmd.set_phase = 1'b1;
                     cmd.phase_val = tva_pkg::PH_ATTACK;
                     voice_done    = 1'b1;
                  end
               end
               default: begin
                  cmd.set_phase = 1'b1;
                  cmd.phase_val = tva_pkg::PH_OFF;
                  voice_done    = 1'b1;
               end
            endcase
         end
         ST_SCALE_MUL: begin
            cmd.mul_scale = 1'b1;
            state_in      = ST_SCALE_USE;
         end
         ST_SCALE_USE: begin
            cmd.scale_update = 1'b1;
            state_in         = ST_OUT_MUL;
         end
         ST_OUT_MUL: begin
            cmd.mul_out = 1'b1;
            state_in    = ST_OUT_USE;
         end
         ST_OUT_USE: begin
            cmd.out_update = 1'b1;
            voice_done     = 1'b1;
         end
         ST_RESP: begin
            // load the result once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Advance to the next voice or finish the tick
      if (voice_done) begin
         if (status.last_voice) begin
            state_in = ST_RESP;
         end else begin
            cmd.voice_next = 1'b1;
            state_in       = ST_EVAL;
         end
      end
   end

   assign rsp_valid_in = cmd.load_rsp || (rsp_valid_ff && rsp_stall);

   // Hold state and registered handshake outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         req_stall_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         req_stall_ff <= (state_in != ST_IDLE);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = req_stall_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/tva_datapath.sv */
// Datapath: configuration registers, per-voice envelope state, the shared
// multiplier with its product register, and the result register.
// Depends on tva_pkg.
`timescale 1ns / 1ps

module tva_datapath #(
   parameter int VOICES = tva_pkg::VOICES_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  tva_pkg::dp_cmd_type             cmd,
   output tva_pkg::dp_status_type          status,
   input  tva_pkg::req_payload_type        req_payload,
   input  logic                            csr_wr_en,
   input  logic [tva_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tva_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output tva_pkg::rsp_payload_type        rsp_payload
);

   localparam int VIDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int SHIFT_W = tva_pkg::PROD_W - tva_pkg::FRAC_BITS;
   localparam int SUM_W   = SHIFT_W + 1;

   // Configuration registers
   logic [tva_pkg::ONTIME_W-1:0]       min_on_time_ff;
   logic [tva_pkg::COEF_W-1:0]         attack_coef_ff;
   logic [tva_pkg::DECAY_COEF_W-1:0]   decay_coef_ff;
   logic [tva_pkg::RELEASE_COEF_W-1:0] release_coef_ff;
   logic                               sustain_en_ff;
   logic [tva_pkg::LEVEL_W-1:0]        sustain_level_ff;

   // Captured transaction
   tva_pkg::op_type              item_op_ff;
   logic                         item_voice_ff;
   logic [tva_pkg::ONTIME_W-1:0] item_req_ff;
   logic                         item_ok;

   // Per-voice state
   tva_pkg::phase_type           phase_ff [0:VOICES-1];
   tva_pkg::phase_type           phase_in [0:VOICES-1];
   logic [tva_pkg::MULT_W-1:0]   mult_ff  [0:VOICES-1];
   logic [tva_pkg::MULT_W-1:0]   mult_in  [0:VOICES-1];
   logic [tva_pkg::ONTIME_W-1:0] req_ff   [0:VOICES-1];
   logic [tva_pkg::ONTIME_W-1:0] req_in   [0:VOICES-1];
   logic [tva_pkg::ONTIME_W-1:0] last_ff  [0:VOICES-1];
   logic [tva_pkg::ONTIME_W-1:0] last_in  [0:VOICES-1];
   logic [tva_pkg::ONTIME_W-1:0] env_ff   [0:VOICES-1];
   logic [tva_pkg::ONTIME_W-1:0] env_in   [0:VOICES-1];

   logic [VIDX_W-1:0] voice_ff;

   // Current voice and arithmetic
   tva_pkg::phase_type           cur_phase;
   logic [tva_pkg::MULT_W-1:0]   cur_mult;
   logic [tva_pkg::ONTIME_W-1:0] req_sel;
   logic [tva_pkg::COEF_W-1:0]   coef_sel;
   logic [tva_pkg::COEF_W-1:0]   mul_b;
   logic                         coef_is_one;
   logic                         release_is_one;
   logic [tva_pkg::PROD_W-1:0]   prod_ff;
   logic [SHIFT_W-1:0]           prod_shift;
   logic [tva_pkg::MULT_W-1:0]   scaled_mult;
   logic [tva_pkg::LEVEL_W-1:0]  level_clamp;
   logic                         below_sustain;
   logic [tva_pkg::MULT_W-1:0]   scale_mult_new;
   tva_pkg::phase_type           scale_phase_new;
   logic [SUM_W-1:0]             ot_sum;
   logic [tva_pkg::ONTIME_W-1:0] on_time_new;
   logic                         release_end;

   logic [tva_pkg::ONTIME_W-1:0] second_env;
   tva_pkg::phase_type           second_phase;
   tva_pkg::rsp_payload_type     rsp_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         min_on_time_ff   <= '0;
         attack_coef_ff   <= tva_pkg::ATTACK_COEF_RESET;
         decay_coef_ff    <= '0;
         release_coef_ff  <= tva_pkg::RELEASE_COEF_RESET;
         sustain_en_ff    <= 1'b0;
         sustain_level_ff <= '0;
      end else if (csr_wr_en) begin
         case (tva_pkg::csr_index_type'(csr_index))
            tva_pkg::CSR_MIN_ON_TIME:
               min_on_time_ff <= csr_wdata[tva_pkg::ONTIME_W-1:0];
            tva_pkg::CSR_ATTACK_COEF:
               attack_coef_ff <= csr_wdata[tva_pkg::COEF_W-1:0];
            tva_pkg::CSR_DECAY_COEF:
               decay_coef_ff <= csr_wdata[tva_pkg::DECAY_COEF_W-1:0];
            tva_pkg::CSR_RELEASE_COEF:
               release_coef_ff <= csr_wdata[tva_pkg::RELEASE_COEF_W-1:0];
            tva_pkg::CSR_SUSTAIN_ENABLED:
               sustain_en_ff <= csr_wdata[0];
            tva_pkg::CSR_SUSTAIN_LEVEL:
               sustain_level_ff <= csr_wdata[tva_pkg::LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture the transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_op_ff    <= tva_pkg::op_type'(req_payload.operation);
         item_voice_ff <= req_payload.voice;
         item_req_ff   <= req_payload.requested_on_time;
      end
   end

   // Drop note events for a voice that is not built
   assign item_ok = (VOICES > 1) || !item_voice_ff;

   // Voice counter
   always_ff @(posedge clock) begin
      if (reset) begin
         voice_ff <= '0;
      end else if (cmd.capture) begin
         voice_ff <= '0;
      end else if (cmd.voice_next) begin
         voice_ff <= voice_ff + VIDX_W'(1);
      end
   end

   // Current voice view
   assign cur_phase = phase_ff[voice_ff];
   assign cur_mult  = mult_ff[voice_ff];
   assign req_sel   = (cur_phase == tva_pkg::PH_RELEASE) ? last_ff[voice_ff] : req_ff[voice_ff];

   // Coefficient of the current phase
   always_comb begin
      case (cur_phase)
         tva_pkg::PH_ATTACK:  coef_sel = attack_coef_ff;
         tva_pkg::PH_DECAY:   coef_sel = tva_pkg::COEF_W'(decay_coef_ff);
         tva_pkg::PH_RELEASE: coef_sel = tva_pkg::COEF_W'(release_coef_ff);
         default:             coef_sel = '0;
      endcase
   end

   assign coef_is_one    = tva_pkg::CMP_W'(coef_sel) == tva_pkg::CMP_W'(tva_pkg::ONE_FX);
   assign release_is_one = tva_pkg::CMP_W'(release_coef_ff) == tva_pkg::CMP_W'(tva_pkg::ONE_FX);

   // Shared multiplier: multiplier times coefficient, or times request
   assign mul_b = cmd.mul_scale ? coef_sel : tva_pkg::COEF_W'(req_sel);

   always_ff @(posedge clock) begin
      if (cmd.mul_scale || cmd.mul_out) begin
         prod_ff <= tva_pkg::PROD_W'(cur_mult) * tva_pkg::PROD_W'(mul_b);
      end
   end

   assign prod_shift  = prod_ff[tva_pkg::PROD_W-1:tva_pkg::FRAC_BITS];
   assign scaled_mult = (|prod_shift[SHIFT_W-1:tva_pkg::MULT_W]) ? tva_pkg::MULT_MAX
                                                                 : prod_shift[tva_pkg::MULT_W-1:0];

   // Decay end test against the clamped sustain level
   assign level_clamp = (sustain_level_ff > tva_pkg::LEVEL_W'(tva_pkg::LEVEL_FULL))
                        ? tva_pkg::LEVEL_W'(tva_pkg::LEVEL_FULL) : sustain_level_ff;
   assign below_sustain =
      (tva_pkg::DEC_W'(scaled_mult) * tva_pkg::DEC_W'(tva_pkg::LEVEL_FULL))
      < (tva_pkg::DEC_W'(level_clamp) << tva_pkg::FRAC_BITS);

   // New multiplier and phase after scaling
   always_comb begin
      scale_mult_new  = scaled_mult;
      scale_phase_new = cur_phase;
      case (cur_phase)
         tva_pkg::PH_ATTACK: begin
            if ((scaled_mult > tva_pkg::ONE_FX) || coef_is_one) begin
               scale_mult_new  = tva_pkg::ONE_FX;
               scale_phase_new = tva_pkg::PH_DECAY;
            end
         end
         tva_pkg::PH_DECAY: begin
            if (below_sustain || coef_is_one) begin
               scale_mult_new  = tva_pkg::SUSTAIN_TABLE[sustain_level_ff];
               scale_phase_new = tva_pkg::PH_SUSTAIN;
            end
         end
         default: ;
      endcase
   end

   // On-time from the product, saturated
   assign ot_sum      = SUM_W'(prod_shift) + SUM_W'(min_on_time_ff);
   assign on_time_new = (|ot_sum[SUM_W-1:tva_pkg::ONTIME_W]) ? '1
                                                            : ot_sum[tva_pkg::ONTIME_W-1:0];
   assign release_end = (cur_phase == tva_pkg::PH_RELEASE)
                        && ((on_time_new == min_on_time_ff) || release_is_one);

   // Next voice state
   always_comb begin
      for (int v = 0; v < VOICES; v++) begin
         phase_in[v] = phase_ff[v];
         mult_in[v]  = mult_ff[v];
         req_in[v]   = req_ff[v];
         last_in[v]  = last_ff[v];
         env_in[v]   = env_ff[v];

         if (cmd.apply_event) begin
            case (item_op_ff)
               tva_pkg::OP_NOTE_START: begin
                  if (item_ok && (VIDX_W'(v) == VIDX_W'(item_voice_ff))) begin
                     req_in[v]   = item_req_ff;
                     phase_in[v] = tva_pkg::PH_OFF;
                  end
               end
               tva_pkg::OP_NOTE_STOP: begin
                  if (item_ok && (VIDX_W'(v) == VIDX_W'(item_voice_ff))) begin
                     last_in[v] = req_ff[v];
                     req_in[v]  = '0;
                  end
               end
               tva_pkg::OP_ALL_OFF: begin
                  req_in[v] = '0;
               end
               default: ;
            endcase
         end

         if (VIDX_W'(v) == voice_ff) begin
            if (cmd.set_phase) begin
               phase_in[v] = cmd.phase_val;
            end
            if (cmd.load_start) begin
               mult_in[v] = tva_pkg::START_MULT;
            end
            if (cmd.clear_out) begin
               env_in[v] = '0;
            end
            if (cmd.scale_update) begin
               mult_in[v]  = scale_mult_new;
               phase_in[v] = scale_phase_new;
            end
            if (cmd.out_update) begin
               if (release_end) begin
                  mult_in[v]  = '0;
                  env_in[v]   = '0;
                  phase_in[v] = tva_pkg::PH_OFF;
               end else begin
                  env_in[v] = on_time_new;
               end
            end
         end
      end
   end

   // Hold voice state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int v = 0; v < VOICES; v++) begin
            phase_ff[v] <= tva_pkg::PH_OFF;
            mult_ff[v]  <= '0;
            req_ff[v]   <= '0;
            last_ff[v]  <= '0;
            env_ff[v]   <= '0;
         end
      end else begin
         for (int v = 0; v < VOICES; v++) begin
            phase_ff[v] <= phase_in[v];
            mult_ff[v]  <= mult_in[v];
            req_ff[v]   <= req_in[v];
            last_ff[v]  <= last_in[v];
            env_ff[v]   <= env_in[v];
         end
      end
   end

   // Second voice shows as silent when only one is built
   if (VOICES > 1) begin : g_second
      assign second_env   = env_ff[1];
      assign second_phase = phase_ff[1];
   end else begin : g_single
      assign second_env   = '0;
      assign second_phase = tva_pkg::PH_OFF;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_ff.on_time_first  <= env_ff[0];
         rsp_ff.on_time_second <= second_env;
         rsp_ff.phase_first    <= phase_ff[0];
         rsp_ff.phase_second   <= second_phase;
         rsp_ff.any_active     <= (env_ff[0] != '0) || (second_env != '0);
      end
   end

   assign rsp_payload = rsp_ff;

   // Status to the controller
   assign status.phase      = cur_phase;
   assign status.req_zero   = (req_ff[voice_ff] == '0);
   assign status.sus_en     = sustain_en_ff;
   assign status.last_voice = (voice_ff == VIDX_W'(VOICES - 1));
   assign status.tick       = (item_op_ff == tva_pkg::OP_TICK);

endmodule
